[sv/cwt_pkg.sv]
// Types and constants shared by the command word tokenizer modules.
package cwt_pkg;

	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_TAB       = 8'h09;
	localparam logic [7:0] CH_NEWLINE   = 8'h0a;
	localparam logic [7:0] CH_RETURN    = 8'h0d;
	localparam logic [7:0] CH_LBRACE    = 8'h7b;
	localparam logic [7:0] CH_RBRACE    = 8'h7d;
	localparam logic [7:0] CH_LBRACKET  = 8'h5b;
	localparam logic [7:0] CH_RBRACKET  = 8'h5d;
	localparam logic [7:0] CH_DOLLAR    = 8'h24;
	localparam logic [7:0] CH_HASH      = 8'h23;
	localparam logic [7:0] CH_BACKSLASH = 8'h5c;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5f;

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PTR_BITS = 3;
	localparam int FIFO_CNT_BITS = 4;

	typedef enum logic [2:0] {
		MODE_BETWEEN,
		MODE_BARE,
		MODE_BRACE,
		MODE_BRACKET,
		MODE_VAR,
		MODE_COMMENT
	} mode_t;

	typedef enum logic [2:0] {
		KIND_BARE,
		KIND_BRACE,
		KIND_BRACKET,
		KIND_VAR,
		KIND_EOL
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK,
		STATUS_UNCLOSED,
		STATUS_SATURATED
	} status_t;

	typedef struct packed {
		kind_t       word_kind;
		logic [15:0] content_start;
		logic [15:0] content_length;
		status_t     line_status;
		logic        last_result;
	} result_t;

	// Up to two results written into the queue in one cycle.
	typedef struct packed {
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

[sv/cwt_in_if.sv]
// Request channel carrying one byte of command text.
interface cwt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_buffer;

	modport source (output valid, output data_byte, output end_of_buffer, input ready);
	modport sink (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

[sv/cwt_out_if.sv]
// Request channel carrying one word token or end-of-line marker.
interface cwt_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  word_kind;
	logic [15:0] content_start;
	logic [15:0] content_length;
	logic [1:0]  line_status;
	logic        last_result;

	modport source (output valid, output word_kind, output content_start,
		output content_length, output line_status, output last_result, input ready);
	modport sink (input valid, input word_kind, input content_start,
		input content_length, input line_status, input last_result, output ready);
endinterface

[sv/command_word_tokenizer_core.sv]
// Command word tokenizer: one byte of command text in, word tokens out.
// Byte requests arrive on in_ch (data_byte, end_of_buffer); each byte is
// registered, then scanned against the current mode in the next cycle and
// gives zero, one or two results: bare, brace, bracket and variable words
// (content offset and length, delimiters excluded) and end-of-line markers
// whose line_status flags an unclosed brace or bracket or saturated nesting.
// last_result marks the final result caused by one byte.
// Results leave on out_ch from an eight-entry queue fed by the input
// register. One byte is accepted every cycle while ready; the bound is
// the single mode update per byte. in_ch.ready drops only when the queue,
// counting the byte in flight, could not hold two more results, so a stalled
// receiver backs up into the sender without losing or repeating a result.
// end_of_buffer flushes an open bare or variable word, emits the line marker
// and returns all scan state, byte offset included, to its reset value.
// arst_n clears the scan state and empties the queue; no clearing pass.
module command_word_tokenizer_core #(
	parameter int OFFSET_BITS = 16,
	parameter int DEPTH_BITS  = 8
) (
	input  logic    clk,
	input  logic    arst_n,
	cwt_in_if.sink  in_ch,
	cwt_out_if.source out_ch
);
	import cwt_pkg::*;

	localparam logic [FIFO_CNT_BITS:0] ROOM_LIMIT = (FIFO_CNT_BITS+1)'(FIFO_DEPTH - 2);

	push_t                    push;
	logic                     pending;
	logic                     take;
	logic                     not_empty;
	result_t                  head;
	logic [FIFO_CNT_BITS-1:0] count;
	logic [FIFO_CNT_BITS:0]   reserved;

	// Hold off a request until two results fit beside the two kept for the byte in flight.
	assign reserved    = {1'b0, count} + (pending ? (FIFO_CNT_BITS+1)'(2) : '0);
	assign in_ch.ready = (reserved <= ROOM_LIMIT);
	assign take        = in_ch.valid && in_ch.ready;

	cwt_scan #(
		.OFFSET_BITS(OFFSET_BITS),
		.DEPTH_BITS (DEPTH_BITS)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.data_byte    (in_ch.data_byte),
		.end_of_buffer(in_ch.end_of_buffer),
		.pending      (pending),
		.push         (push)
	);

	cwt_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pop      (out_ch.ready),
		.not_empty(not_empty),
		.head     (head),
		.count    (count)
	);

	assign out_ch.valid          = not_empty;
	assign out_ch.word_kind      = head.word_kind;
	assign out_ch.content_start  = head.content_start;
	assign out_ch.content_length = head.content_length;
	assign out_ch.line_status    = head.line_status;
	assign out_ch.last_result    = head.last_result;

endmodule

[sv/cwt_scan.sv]
// Scanner: input register, tokenizer state and the results of one byte.
module cwt_scan #(
	parameter int OFFSET_BITS = 16,
	parameter int DEPTH_BITS  = 8
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  logic [7:0]     data_byte,
	input  logic           end_of_buffer,
	output logic           pending,
	output cwt_pkg::push_t push
);
	import cwt_pkg::*;

	localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};
	localparam logic [OFFSET_BITS-1:0] OFF_ONE = {{(OFFSET_BITS-1){1'b0}}, 1'b1};
	localparam logic [DEPTH_BITS-1:0] DEPTH_ONE = {{(DEPTH_BITS-1){1'b0}}, 1'b1};

	logic                   valid_s1;
	logic [7:0]             c_s1;
	logic                   eob_s1;

	mode_t                  mode_q, mode_d;
	logic [DEPTH_BITS-1:0]  depth_q, depth_d;
	logic                   esc_q, esc_d;
	logic                   prev_bs_q, prev_bs_d;
	logic [OFFSET_BITS-1:0] off_q, off_d;
	logic [OFFSET_BITS-1:0] ws_q, ws_d;
	logic                   sat_q, sat_d;

	logic is_ws, is_eol, is_name, is_sep, is_bs;
	logic in_nest, nest_open, nest_close, close_done, go_between;
	logic opens_nest, opens_var, bare_start, eol_ev, word_ev;
	logic flush_word, flush_eol;
	logic [7:0] open_ch, close_ch;
	logic [DEPTH_BITS-1:0] depth_dec;
	mode_t mode_mid;
	logic [OFFSET_BITS-1:0] ws_mid, word_len, flush_len;
	logic [DEPTH_BITS-1:0] depth_mid;
	logic esc_mid, sat_mid;
	kind_t word_kind, flush_kind;
	status_t eol_status, flush_status;

	result_t cand [4];
	logic [3:0] cand_v;
	result_t r0, r1;
	logic [1:0] n;

	function automatic logic [15:0] to16(input logic [OFFSET_BITS-1:0] v);
		logic [OFFSET_BITS+15:0] w;
		w = {16'b0, v};
		return w[15:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			c_s1   <= data_byte;
			eob_s1 <= end_of_buffer;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_BETWEEN;
			depth_q   <= '0;
			esc_q     <= 1'b0;
			prev_bs_q <= 1'b0;
			off_q     <= '0;
			ws_q      <= '0;
			sat_q     <= 1'b0;
		end else if (valid_s1) begin
			mode_q    <= mode_d;
			depth_q   <= depth_d;
			esc_q     <= esc_d;
			prev_bs_q <= prev_bs_d;
			off_q     <= off_d;
			ws_q      <= ws_d;
			sat_q     <= sat_d;
		end
	end

	// Decode the byte against the current mode.
	always_comb begin
		is_ws   = (c_s1 == CH_SPACE) || (c_s1 == CH_TAB);
		is_eol  = (c_s1 == CH_NEWLINE) || (c_s1 == CH_RETURN);
		is_name = (c_s1 inside {[8'h61:8'h7a], [8'h41:8'h5a], [8'h30:8'h39], CH_UNDERSCORE});
		is_sep  = is_ws || is_eol || (c_s1 == CH_HASH);
		is_bs   = (c_s1 == CH_BACKSLASH);

		in_nest  = (mode_q == MODE_BRACE) || (mode_q == MODE_BRACKET);
		open_ch  = (mode_q == MODE_BRACE) ? CH_LBRACE : CH_LBRACKET;
		close_ch = (mode_q == MODE_BRACE) ? CH_RBRACE : CH_RBRACKET;
		nest_open  = in_nest && (c_s1 == open_ch);
		nest_close = in_nest && (c_s1 == close_ch) && !esc_q;
		depth_dec  = (depth_q != '0) ? depth_q - DEPTH_ONE : depth_q;
		close_done = nest_close && (depth_dec == '0);

		case (mode_q)
			MODE_BARE:    go_between = is_sep;
			MODE_BRACE,
			MODE_BRACKET: go_between = 1'b0;
			MODE_VAR:     go_between = !is_name;
			MODE_COMMENT: go_between = (c_s1 == CH_NEWLINE);
			default:      go_between = 1'b1;
		endcase

		word_len = off_q - ws_q;
		case (mode_q)
			MODE_BARE:    word_kind = KIND_BARE;
			MODE_BRACE:   word_kind = KIND_BRACE;
			MODE_BRACKET: word_kind = KIND_BRACKET;
			default:      word_kind = KIND_VAR;
		endcase
		word_ev = ((mode_q == MODE_BARE) && is_sep)
			|| ((mode_q == MODE_VAR) && !is_name && (word_len != '0))
			|| close_done;

		opens_nest = go_between && ((c_s1 == CH_LBRACE) || (c_s1 == CH_LBRACKET));
		opens_var  = go_between && (c_s1 == CH_DOLLAR);
		bare_start = go_between && !is_ws && !is_eol && (c_s1 != CH_HASH)
			&& (c_s1 != CH_LBRACE) && (c_s1 != CH_LBRACKET) && (c_s1 != CH_DOLLAR);
		eol_ev     = go_between && is_eol && !prev_bs_q;
		eol_status = sat_q ? STATUS_SATURATED : STATUS_OK;
	end

	// Next state.
	always_comb begin
		if (go_between) begin
			if (is_ws || is_eol) begin
				mode_mid = MODE_BETWEEN;
			end else if (c_s1 == CH_HASH) begin
				mode_mid = MODE_COMMENT;
			end else if (c_s1 == CH_LBRACE) begin
				mode_mid = MODE_BRACE;
			end else if (c_s1 == CH_LBRACKET) begin
				mode_mid = MODE_BRACKET;
			end else if (c_s1 == CH_DOLLAR) begin
				mode_mid = MODE_VAR;
			end else begin
				mode_mid = MODE_BARE;
			end
		end else if (close_done) begin
			mode_mid = MODE_BETWEEN;
		end else begin
			mode_mid = mode_q;
		end

		if (opens_nest || opens_var) begin
			ws_mid = off_q + OFF_ONE;
		end else if (bare_start) begin
			ws_mid = off_q;
		end else begin
			ws_mid = ws_q;
		end

		if (eol_ev) begin
			depth_mid = '0;
		end else if (opens_nest) begin
			depth_mid = DEPTH_ONE;
		end else if (nest_open && !esc_q && (depth_q != DEPTH_MAX)) begin
			depth_mid = depth_q + DEPTH_ONE;
		end else if (nest_close) begin
			depth_mid = depth_dec;
		end else begin
			depth_mid = depth_q;
		end

		if (eol_ev || opens_nest) begin
			esc_mid = 1'b0;
		end else if (in_nest) begin
			esc_mid = ((c_s1 == open_ch) || (c_s1 == close_ch)) ? 1'b0 : is_bs;
		end else begin
			esc_mid = esc_q;
		end

		if (eol_ev) begin
			sat_mid = 1'b0;
		end else if (nest_open && !esc_q && (depth_q == DEPTH_MAX)) begin
			sat_mid = 1'b1;
		end else begin
			sat_mid = sat_q;
		end

		if (eob_s1) begin
			mode_d    = MODE_BETWEEN;
			depth_d   = '0;
			esc_d     = 1'b0;
			prev_bs_d = 1'b0;
			off_d     = '0;
			ws_d      = '0;
			sat_d     = 1'b0;
		end else begin
			mode_d    = mode_mid;
			depth_d   = depth_mid;
			esc_d     = esc_mid;
			prev_bs_d = is_bs;
			off_d     = off_q + OFF_ONE;
			ws_d      = ws_mid;
			sat_d     = sat_mid;
		end
	end

	// Results: word, line end, flushed word, flushed line end; keep the first two.
	always_comb begin
		flush_len  = off_q + OFF_ONE - ws_mid;
		flush_kind = (mode_mid == MODE_BARE) ? KIND_BARE : KIND_VAR;
		flush_word = eob_s1 && ((mode_mid == MODE_BARE)
			|| ((mode_mid == MODE_VAR) && (flush_len != '0)));
		flush_eol  = eob_s1 && !eol_ev;
		if ((mode_mid == MODE_BRACE) || (mode_mid == MODE_BRACKET)) begin
			flush_status = STATUS_UNCLOSED;
		end else begin
			flush_status = sat_mid ? STATUS_SATURATED : STATUS_OK;
		end

		cand[0] = '{word_kind, to16(ws_q), to16(word_len), STATUS_OK, 1'b0};
		cand[1] = '{KIND_EOL, to16(off_q), 16'd0, eol_status, 1'b0};
		cand[2] = '{flush_kind, to16(ws_mid), to16(flush_len), STATUS_OK, 1'b0};
		cand[3] = '{KIND_EOL, to16(off_q), 16'd0, flush_status, 1'b0};
		cand_v  = {flush_eol, flush_word, eol_ev, word_ev};

		r0 = cand[0];
		r1 = cand[0];
		n  = 2'd0;
		for (int i = 0; i < 4; i++) begin
			if (cand_v[i]) begin
				if (n == 2'd0) begin
					r0 = cand[i];
					n  = 2'd1;
				end else if (n == 2'd1) begin
					r1 = cand[i];
					n  = 2'd2;
				end
			end
		end
		r0.last_result = (n == 2'd1);
		r1.last_result = 1'b1;

		push.cnt = valid_s1 ? n : 2'd0;
		push.r0  = r0;
		push.r1  = r1;
		pending  = valid_s1;
	end

endmodule

[sv/cwt_fifo.sv]
// Result queue that takes up to two results a cycle and hands out one.
module cwt_fifo (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cwt_pkg::push_t                   push,
	input  logic                             pop,
	output logic                             not_empty,
	output cwt_pkg::result_t                 head,
	output logic [cwt_pkg::FIFO_CNT_BITS-1:0] count
);
	import cwt_pkg::*;

	result_t                  mem [FIFO_DEPTH];
	logic [FIFO_PTR_BITS-1:0] wr_q, rd_q;
	logic [FIFO_CNT_BITS-1:0] cnt_q;
	logic [FIFO_PTR_BITS-1:0] wr_next;
	logic                     do_pop;

	assign wr_next   = wr_q + FIFO_PTR_BITS'(1);
	assign not_empty = (cnt_q != '0);
	assign do_pop    = pop && not_empty;
	assign head      = mem[rd_q];
	assign count     = cnt_q;

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem[wr_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			mem[wr_next] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + FIFO_PTR_BITS'(push.cnt);
			rd_q  <= rd_q + FIFO_PTR_BITS'(do_pop);
			cnt_q <= cnt_q + FIFO_CNT_BITS'(push.cnt) - FIFO_CNT_BITS'(do_pop);
		end
	end

endmodule
